FILE: rtl/core/nmea_gsa_vdop_extractor_defines.svh
// Assertion macros shared by the extractor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef NMEA_GSA_VDOP_EXTRACTOR_DEFINES_SVH
`define NMEA_GSA_VDOP_EXTRACTOR_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define NGE_AST_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define NGE_AST_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/nge_pkg.sv
// Shared types and character codes for the GSA vertical dilution extractor.
// No dependencies.
package nge_pkg;

	// One result transaction
	typedef struct packed {
		logic signed [15:0] vdop_centi;
		logic               saturated;
	} nge_result_t;

	// ASCII codes the parser reacts to
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_A      = 8'h41;

	// Magnitude limits in hundredths
	localparam logic [15:0] MAG_POS_MAX = 16'd32767;
	localparam logic [15:0] MAG_NEG_MAX = 16'd32768;

endpackage

FILE: rtl/core/nge_track.sv
// Input register and per-byte line tracker / number parser.
// Depends on nge_pkg and nmea_gsa_vdop_extractor_defines.svh.
`include "nmea_gsa_vdop_extractor_defines.svh"

module nge_track #(
	parameter int LINE_BYTES  = 80,
	parameter int FIELD_INDEX = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	output logic                 in_stall,
	input  logic                 res_room,
	output logic                 res_push,
	output nge_pkg::nge_result_t res_data
);
	import nge_pkg::*;

	localparam int LW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
	localparam int CW = $clog2(FIELD_INDEX + 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(LINE_BYTES - 1);
	localparam logic [CW-1:0] FIELD   = CW'(FIELD_INDEX);

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_BLANK,
		PH_INT,
		PH_FRAC,
		PH_DONE
	} phase_t;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Line state
	logic [LW-1:0] len_q,   len_n,   len_e;
	logic [15:0]   tail_q,  tail_n,  tail_e;
	logic          gsa_q,   gsa_n,   gsa_e;
	logic [CW-1:0] cc_q,    cc_n,    cc_e;
	phase_t        ph_q,    ph_n,    ph_e;
	logic          neg_q,   neg_n,   neg_e;
	logic [15:0]   acc_q,   acc_n,   acc_e;
	logic [1:0]    frac_q,  frac_n,  frac_e;
	logic          clamp_q, clamp_n, clamp_e;

	logic          proc, keep, is_dig, is_blank, take, take_int;
	logic [7:0]    c;
	logic [3:0]    dig;
	logic [19:0]   cand, lim;

	assign proc     = valid_s1 && res_room;
	assign in_stall = valid_s1 && !res_room;
	assign c        = byte_s1;
	assign dig      = 4'(c - CH_ZERO);
	assign is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
	                  (c == CH_VT) || (c == CH_FF) || (c == CH_CR);

	// Next state for the byte in the input stage
	always_comb begin
		// a dollar restarts the line before the byte is counted
		if (c == CH_DOLLAR) begin
			len_e = '0; tail_e = '0; gsa_e = 1'b0; cc_e = '0; ph_e = PH_WAIT;
			neg_e = 1'b0; acc_e = '0; frac_e = '0; clamp_e = 1'b0;
		end else begin
			len_e = len_q; tail_e = tail_q; gsa_e = gsa_q; cc_e = cc_q; ph_e = ph_q;
			neg_e = neg_q; acc_e = acc_q; frac_e = frac_q; clamp_e = clamp_q;
		end
		len_n = len_e; tail_n = tail_e; gsa_n = gsa_e; cc_n = cc_e; ph_n = ph_e;
		neg_n = neg_e; acc_n = acc_e; frac_n = frac_e; clamp_n = clamp_e;
		take = 1'b0;
		take_int = 1'b0;
		keep = len_e < LEN_MAX;
		if (keep) begin
			len_n  = len_e + 1'b1;
			if (c == CH_A && tail_e == {CH_G, CH_S})
				gsa_n = 1'b1;
			tail_n = {tail_e[7:0], c};
			if (cc_e < FIELD) begin
				if (c == CH_COMMA) begin
					cc_n = cc_e + 1'b1;
					if (cc_n == FIELD)
						ph_n = PH_BLANK;
				end
			end else begin
				case (ph_e)
					PH_BLANK: begin
						if (is_blank) begin
							ph_n = PH_BLANK;
						end else if (c == CH_PLUS) begin
							ph_n = PH_INT;
						end else if (c == CH_MINUS) begin
							neg_n = 1'b1;
							ph_n  = PH_INT;
						end else if (is_dig) begin
							ph_n     = PH_INT;
							take     = 1'b1;
							take_int = 1'b1;
						end else if (c == CH_DOT) begin
							ph_n = PH_FRAC;
						end else begin
							ph_n = PH_DONE;
						end
					end
					PH_INT: begin
						if (is_dig) begin
							take     = 1'b1;
							take_int = 1'b1;
						end else if (c == CH_DOT) begin
							ph_n = PH_FRAC;
						end else begin
							ph_n = PH_DONE;
						end
					end
					PH_FRAC: begin
						if (is_dig)
							take = 1'b1;
						else
							ph_n = PH_DONE;
					end
					default: ;
				endcase
			end
		end

		// digit accumulation in hundredths, clamped once out of range
		if (take_int)
			cand = 20'(acc_e) * 20'd10 + 20'(dig) * 20'd100;
		else if (frac_e == 2'd0)
			cand = 20'(acc_e) + 20'(dig) * 20'd10;
		else
			cand = 20'(acc_e) + 20'(dig);
		lim = neg_e ? 20'(MAG_NEG_MAX) : 20'(MAG_POS_MAX);
		if (take && (take_int || frac_e != 2'd2)) begin
			if (!take_int)
				frac_n = frac_e + 1'b1;
			if (!clamp_e) begin
				if (cand > lim) begin
					acc_n   = lim[15:0];
					clamp_n = 1'b1;
				end else begin
					acc_n = cand[15:0];
				end
			end
		end
	end

	// Result for a kept newline on a qualifying line
	assign res_push            = proc && keep && (c == CH_LF) && gsa_n && (cc_n == FIELD);
	assign res_data.vdop_centi = neg_n ? -acc_n : acc_n;
	assign res_data.saturated  = clamp_n;

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= in_byte;
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0; tail_q <= '0; gsa_q <= 1'b0; cc_q <= '0; ph_q <= PH_WAIT;
			neg_q <= 1'b0; acc_q <= '0; frac_q <= '0; clamp_q <= 1'b0;
		end else if (proc) begin
			len_q <= len_n; tail_q <= tail_n; gsa_q <= gsa_n; cc_q <= cc_n; ph_q <= ph_n;
			neg_q <= neg_n; acc_q <= acc_n; frac_q <= frac_n; clamp_q <= clamp_n;
		end
	end

	`NGE_AST_ALWAYS(a_len_range, len_q <= LEN_MAX, "line length past limit")
	`NGE_AST_ALWAYS(a_comma_range, cc_q <= FIELD, "comma count past field index")
	`NGE_AST_ALWAYS(a_clamp_value, !clamp_q || acc_q == MAG_POS_MAX || acc_q == MAG_NEG_MAX,
		"clamped magnitude not at a limit")
endmodule

FILE: rtl/core/nge_outbuf.sv
// Two-entry result buffer that decouples the parser from the output stall.
// Depends on nge_pkg and nmea_gsa_vdop_extractor_defines.svh.
`include "nmea_gsa_vdop_extractor_defines.svh"

module nge_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  nge_pkg::nge_result_t push_data,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_stall,
	output nge_pkg::nge_result_t head
);
	import nge_pkg::*;

	nge_result_t mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign out_valid = count_q != 2'd0;
	assign room      = count_q != 2'd2;
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	`NGE_AST_ALWAYS(a_count_range, count_q <= 2'd2, "buffer count out of range")
	`NGE_AST_ALWAYS(a_no_overflow, !(push && !room), "push into full buffer")
	`NGE_AST_NEXT(a_drain_last, pop && !push && count_q == 2'd1, !out_valid,
		"buffer not empty after last pop")
endmodule

FILE: rtl/core/nmea_gsa_vdop_extractor.sv
// Top level of the GSA vertical dilution extractor.
// Depends on nge_pkg, nge_track and nge_outbuf.
//
// channel | direction | handshake              | payload
// --------+-----------+------------------------+-----------------------
// input   | in        | in_valid / in_stall    | in_byte
// output  | out       | out_valid / out_stall  | vdop_centi, saturated
//
// One byte per cycle while the result buffer has room; an accepted byte is
// registered in nge_track, and a newline's result is then registered in the
// result buffer. The byte rate is set by the line-state update in nge_track.
// Reset clears the line state and empties the result buffer; no sweep.
// Input stalls only when the two-entry result buffer is full.

module nmea_gsa_vdop_extractor #(
	parameter int LINE_BYTES  = 80,
	parameter int FIELD_INDEX = 17
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] vdop_centi,
	output logic               saturated
);
	import nge_pkg::*;

	logic        res_room, res_push;
	nge_result_t res_data, head;

	// Line tracking and number parsing
	nge_track #(
		.LINE_BYTES (LINE_BYTES),
		.FIELD_INDEX(FIELD_INDEX)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_byte (in_byte),
		.in_stall(in_stall),
		.res_room(res_room),
		.res_push(res_push),
		.res_data(res_data)
	);

	// Result buffer
	nge_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data(res_data),
		.room     (res_room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (head)
	);

	assign vdop_centi = head.vdop_centi;
	assign saturated  = head.saturated;
endmodule
